@@ sv/usbreq_pkg.sv @@
// shared types, request codes and helpers for the standard request handler
// used by usbreq_cfg, usbreq_decode and usb_standard_request_handler
package usbreq_pkg;

	// response kinds
	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_ACK   = 2'd1,
		ACT_DATA  = 2'd2,
		ACT_STALL = 2'd3
	} action_t;

	// where a data-in stage takes its bytes from
	typedef enum logic [2:0] {
		SRC_DEVICE = 3'd0,
		SRC_CONFIG = 3'd1,
		SRC_STR0   = 3'd2,
		SRC_STR1   = 3'd3,
		SRC_STR2   = 3'd4,
		SRC_REPORT = 3'd5,
		SRC_INLINE = 3'd6
	} source_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_DEVICE_DESC_LEN = 3'd0,
		CFG_CONFIG_DESC_LEN = 3'd1,
		CFG_STRING0_LEN     = 3'd2,
		CFG_STRING1_LEN     = 3'd3,
		CFG_STRING2_LEN     = 3'd4,
		CFG_REPORT_DESC_LEN = 3'd5,
		CFG_SELF_POWERED    = 3'd6
	} cfg_idx_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	// bRequest codes
	localparam logic [7:0] REQ_GET_STATUS    = 8'h00;
	localparam logic [7:0] REQ_CLEAR_FEATURE = 8'h01;
	localparam logic [7:0] REQ_SET_FEATURE   = 8'h03;
	localparam logic [7:0] REQ_SET_ADDRESS   = 8'h05;
	localparam logic [7:0] REQ_GET_DESC      = 8'h06;
	localparam logic [7:0] REQ_GET_CONFIG    = 8'h08;
	localparam logic [7:0] REQ_SET_CONFIG    = 8'h09;
	localparam logic [7:0] REQ_GET_IFACE     = 8'h0a;
	localparam logic [7:0] REQ_SET_IFACE     = 8'h0b;

	// bmRequestType values
	localparam logic [7:0] RT_OUT_DEVICE  = 8'h00;
	localparam logic [7:0] RT_OUT_EP      = 8'h02;
	localparam logic [7:0] RT_IN_DEVICE   = 8'h80;
	localparam logic [7:0] RT_IN_IFACE    = 8'h81;
	localparam logic [7:0] RT_IN_EP       = 8'h82;

	// descriptor types in the high byte of wValue
	localparam logic [7:0] DESC_DEVICE = 8'h01;
	localparam logic [7:0] DESC_CONFIG = 8'h02;
	localparam logic [7:0] DESC_STRING = 8'h03;
	localparam logic [7:0] DESC_REPORT = 8'h22;

	localparam logic [15:0] FEAT_REMOTE_WAKEUP = 16'h0001;

	typedef struct packed {
		logic [7:0]  request_type;
		logic [7:0]  request_code;
		logic [15:0] value_field;
		logic [15:0] index_field;
		logic [15:0] length_field;
	} req_t;

	typedef struct packed {
		action_t    action;
		logic       handled;
		source_t    data_source;
		logic [9:0] data_len;
		logic [7:0] reply_byte0;
		logic [7:0] reply_byte1;
	} rsp_t;

	typedef struct packed {
		logic [6:0] address;
		logic [7:0] configuration;
		logic [7:0] alternate;
		logic       wakeup;
		logic       halt_ep0;
		logic       halt_ep1;
	} dev_state_t;

	typedef struct packed {
		logic [7:0] device_desc_len;
		logic [9:0] config_desc_len;
		logic [7:0] string0_len;
		logic [7:0] string1_len;
		logic [7:0] string2_len;
		logic [9:0] report_desc_len;
		logic       self_powered;
	} cfg_t;

	// smaller of the host's wLength and the source size
	function automatic logic [9:0] clamp_len(logic [15:0] req, logic [9:0] size);
		logic [9:0] res;
		if (req < {6'd0, size}) begin
			res = req[9:0];
		end else begin
			res = size;
		end
		return res;
	endfunction

endpackage

@@ sv/usbreq_cfg.sv @@
// configuration registers of the standard request handler
// depends on usbreq_pkg
module usbreq_cfg (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [usbreq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [usbreq_pkg::CFG_DATA_W-1:0]      cfg_data,
	output usbreq_pkg::cfg_t                       cfg
);
	import usbreq_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_desc_len <= 8'd18;
			cfg_q.config_desc_len <= 10'd34;
			cfg_q.string0_len     <= 8'd4;
			cfg_q.string1_len     <= 8'd0;
			cfg_q.string2_len     <= 8'd0;
			cfg_q.report_desc_len <= 10'd63;
			cfg_q.self_powered    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DEVICE_DESC_LEN: cfg_q.device_desc_len <= cfg_data[7:0];
				CFG_CONFIG_DESC_LEN: cfg_q.config_desc_len <= cfg_data;
				CFG_STRING0_LEN:     cfg_q.string0_len     <= cfg_data[7:0];
				CFG_STRING1_LEN:     cfg_q.string1_len     <= cfg_data[7:0];
				CFG_STRING2_LEN:     cfg_q.string2_len     <= cfg_data[7:0];
				CFG_REPORT_DESC_LEN: cfg_q.report_desc_len <= cfg_data;
				CFG_SELF_POWERED:    cfg_q.self_powered    <= cfg_data[0];
				default: begin
					// writes beyond the register list are dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/usbreq_decode.sv @@
// request decode: response and next device state for one setup packet
// purely combinational; depends on usbreq_pkg
module usbreq_decode (
	input  usbreq_pkg::req_t       req,
	input  usbreq_pkg::dev_state_t cur,
	input  usbreq_pkg::cfg_t       cfg,
	output usbreq_pkg::rsp_t       rsp,
	output usbreq_pkg::dev_state_t nxt
);
	import usbreq_pkg::*;

	logic ep_is0;
	logic setv;

	assign ep_is0 = (req.index_field[3:0] == 4'd0);
	assign setv   = (req.request_code == REQ_SET_FEATURE);

	always_comb begin
		rsp.action      = ACT_NONE;
		rsp.handled     = 1'b1;
		rsp.data_source = SRC_DEVICE;
		rsp.data_len    = 10'd0;
		rsp.reply_byte0 = 8'd0;
		rsp.reply_byte1 = 8'd0;
		nxt             = cur;

		unique case (req.request_code)
			REQ_GET_STATUS: begin
				if (req.request_type == RT_IN_DEVICE ||
				    req.request_type == RT_IN_IFACE ||
				    req.request_type == RT_IN_EP) begin
					rsp.action      = ACT_DATA;
					rsp.data_source = SRC_INLINE;
					rsp.data_len    = clamp_len(req.length_field, 10'd2);
					if (req.request_type == RT_IN_DEVICE) begin
						rsp.reply_byte0 = {6'd0, cur.wakeup, cfg.self_powered};
					end else if (req.request_type == RT_IN_EP) begin
						rsp.reply_byte0 = {7'd0, ep_is0 ? cur.halt_ep0 : cur.halt_ep1};
					end
				end else begin
					rsp.action  = ACT_STALL;
					rsp.handled = 1'b0;
				end
			end
			REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
				if (req.request_type == RT_OUT_DEVICE) begin
					if (req.value_field == FEAT_REMOTE_WAKEUP) begin
						nxt.wakeup = setv;
						rsp.action = ACT_ACK;
					end else begin
						rsp.action = ACT_STALL;
					end
				end else if (req.request_type == RT_OUT_EP) begin
					if (ep_is0) begin
						nxt.halt_ep0 = setv;
					end else begin
						nxt.halt_ep1 = setv;
					end
					rsp.action = ACT_ACK;
				end
			end
			REQ_SET_ADDRESS: begin
				nxt.address = req.value_field[6:0];
				rsp.action  = ACT_ACK;
			end
			REQ_GET_DESC: begin
				unique case (req.value_field[15:8])
					DESC_DEVICE: begin
						rsp.action      = ACT_DATA;
						rsp.data_source = SRC_DEVICE;
						rsp.data_len    = clamp_len(req.length_field,
							{2'd0, cfg.device_desc_len});
					end
					DESC_CONFIG: begin
						rsp.action      = ACT_DATA;
						rsp.data_source = SRC_CONFIG;
						rsp.data_len    = clamp_len(req.length_field, cfg.config_desc_len);
					end
					DESC_STRING: begin
						rsp.action = ACT_DATA;
						unique case (req.value_field[7:0])
							8'd0: begin
								rsp.data_source = SRC_STR0;
								rsp.data_len    = clamp_len(req.length_field,
									{2'd0, cfg.string0_len});
							end
							8'd1: begin
								rsp.data_source = SRC_STR1;
								rsp.data_len    = clamp_len(req.length_field,
									{2'd0, cfg.string1_len});
							end
							8'd2: begin
								rsp.data_source = SRC_STR2;
								rsp.data_len    = clamp_len(req.length_field,
									{2'd0, cfg.string2_len});
							end
							default: begin
								// unknown string: empty inline reply
								rsp.data_source = SRC_INLINE;
							end
						endcase
					end
					DESC_REPORT: begin
						rsp.action      = ACT_DATA;
						rsp.data_source = SRC_REPORT;
						rsp.data_len    = clamp_len(req.length_field, cfg.report_desc_len);
					end
					default: begin
						rsp.action  = ACT_STALL;
						rsp.handled = 1'b0;
					end
				endcase
			end
			REQ_GET_CONFIG: begin
				rsp.action      = ACT_DATA;
				rsp.data_source = SRC_INLINE;
				rsp.reply_byte0 = cur.configuration;
				rsp.data_len    = clamp_len(req.length_field, 10'd1);
			end
			REQ_SET_CONFIG: begin
				nxt.configuration = req.value_field[7:0];
				rsp.action        = ACT_ACK;
			end
			REQ_GET_IFACE: begin
				rsp.action      = ACT_DATA;
				rsp.data_source = SRC_INLINE;
				rsp.reply_byte0 = cur.alternate;
				rsp.data_len    = clamp_len(req.length_field, 10'd1);
			end
			REQ_SET_IFACE: begin
				nxt.alternate = req.value_field[7:0];
				rsp.action    = ACT_ACK;
			end
			default: begin
				rsp.action  = ACT_STALL;
				rsp.handled = 1'b0;
			end
		endcase
	end

endmodule

@@ sv/usb_standard_request_handler.sv @@
// top level of the usb standard request handler: setup item register,
// decode, result register and device state; depends on usbreq_pkg,
// usbreq_cfg and usbreq_decode
//
// Takes one decoded setup packet per item and returns exactly one result item:
// nothing, a status acknowledge, a data-in stage (descriptor or up to two inline
// bytes, length clamped to wLength and the source size) or a stall of
// endpoint zero. An accepted item is held in the setup register and passes
// through the decode into the result register once that register is empty
// or drains; the result is then valid and can be taken at an edge where
// rsp_stall is low. The device state (address, configuration, alternate
// setting, remote wakeup, halt flags) is updated at the same edge as the
// result register. One item can be accepted every cycle while req_stall is low; the result register
// and the setup register together let a new item in while a finished result
// still waits, and req_stall rises only when both are full and rsp_stall
// holds the result.
// Configuration registers (sizes and self powered bit) are written through
// cfg_we/cfg_index/cfg_data and should be changed only while no item is in
// flight. The state fields of a result show the device state after that item.
module usb_standard_request_handler (
	input  logic        clk,
	input  logic        arst_n,

	// configuration write port
	input  logic                                  cfg_we,
	input  logic [usbreq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [usbreq_pkg::CFG_DATA_W-1:0]     cfg_data,

	// setup item channel
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [7:0]  request_type,
	input  logic [7:0]  request_code,
	input  logic [15:0] value_field,
	input  logic [15:0] index_field,
	input  logic [15:0] length_field,

	// result item channel
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  action,
	output logic        handled,
	output logic [2:0]  data_source,
	output logic [9:0]  data_len,
	output logic [7:0]  reply_byte0,
	output logic [7:0]  reply_byte1,
	output logic [6:0]  device_address,
	output logic [7:0]  current_configuration,
	output logic        remote_wakeup_enabled,
	output logic        ep0_halted,
	output logic        ep1_halted
);
	import usbreq_pkg::*;

	cfg_t       cfg;
	req_t       req_s1;
	logic       valid_s1;
	rsp_t       rsp_s2;
	logic       valid_s2;
	dev_state_t state_q;
	rsp_t       rsp_d;
	dev_state_t state_d;
	logic       load_s1;
	logic       adv_s1;

	usbreq_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	usbreq_decode u_decode (
		.req (req_s1),
		.cur (state_q),
		.cfg (cfg),
		.rsp (rsp_d),
		.nxt (state_d)
	);

	// setup register moves on when the result register is empty or drains
	assign adv_s1    = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && valid_s2 && rsp_stall;
	assign load_s1   = req_valid && !req_stall;

	// setup item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			req_s1.request_type <= request_type;
			req_s1.request_code <= request_code;
			req_s1.value_field  <= value_field;
			req_s1.index_field  <= index_field;
			req_s1.length_field <= length_field;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_s2 <= rsp_d;
		end
	end

	// device state, committed as the item enters the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_d;
		end
	end

	assign rsp_valid   = valid_s2;
	assign action      = rsp_s2.action;
	assign handled     = rsp_s2.handled;
	assign data_source = rsp_s2.data_source;
	assign data_len    = rsp_s2.data_len;
	assign reply_byte0 = rsp_s2.reply_byte0;
	assign reply_byte1 = rsp_s2.reply_byte1;

	// state only changes together with a result load, so the live state
	// is the state after the item now held in the result register
	assign device_address        = state_q.address;
	assign current_configuration = state_q.configuration;
	assign remote_wakeup_enabled = state_q.wakeup;
	assign ep0_halted            = state_q.halt_ep0;
	assign ep1_halted            = state_q.halt_ep1;

	// device state moves only when an item passes into the result register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(state_q))
		else $error("device state changed without an item");

	// the input side is held back only with both registers full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && valid_s2))
		else $error("setup channel stalled with room to spare");

	// an item leaving the setup register is always shown next cycle
	a_adv_shown: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> rsp_valid)
		else $error("advanced item not presented");

	// no data stage means no length, source or reply bytes
	a_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_s2.action != ACT_DATA) |->
			(data_len == 10'd0 && data_source == SRC_DEVICE &&
			 reply_byte0 == 8'd0 && reply_byte1 == 8'd0))
		else $error("data fields set without a data stage");

endmodule
